### hdl/sbrc_pkg.sv
// Shared types, constants and a saturation helper function for the scaled blit rectangle clip unit.
package sbrc_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COORD_W     = 16;
    localparam int TEX_W       = 15;
    localparam int FIX_W       = 32;
    localparam int DIST_W      = FIX_W + 1;
    localparam int DIV_W       = 32;
    localparam int DIV_BITS    = 4;
    localparam int DIV_STAGES  = DIV_W / DIV_BITS;
    localparam int STAGES      = DIV_STAGES + 6;
    localparam int IN_FIELDS_W = 4 * COORD_W + 2 * TEX_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 4 + 8 * FIX_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int PLO_W       = FIX_W + FRAC_BITS + 1;
    localparam int SUM_W       = PLO_W + 1;

    localparam logic signed [FIX_W-1:0] CLIP_LEFT_RST   = 32'sd0;
    localparam logic signed [FIX_W-1:0] CLIP_RIGHT_RST  = 32'sd20971520;
    localparam logic signed [FIX_W-1:0] CLIP_TOP_RST    = 32'sd0;
    localparam logic signed [FIX_W-1:0] CLIP_BOTTOM_RST = 32'sd13107200;
    localparam logic [FIX_W-1:0] FIX_MAX = 32'h7FFF_FFFF;
    localparam logic [FIX_W-1:0] FIX_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        CFG_CLIP_LEFT   = 2'd0,
        CFG_CLIP_RIGHT  = 2'd1,
        CFG_CLIP_TOP    = 2'd2,
        CFG_CLIP_BOTTOM = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        EDGE_LEFT   = 2'd0,
        EDGE_RIGHT  = 2'd1,
        EDGE_TOP    = 2'd2,
        EDGE_BOTTOM = 2'd3
    } t_edge;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] xe;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] ye;
        logic [TEX_W-1:0]   tw;
        logic [TEX_W-1:0]   th;
    } t_astage;

    typedef struct packed {
        logic              rej;
        logic [3:0]        flags;
        logic [FIX_W-1:0]  sx;
        logic [FIX_W-1:0]  sy;
        logic [FIX_W-1:0]  ex;
        logic [FIX_W-1:0]  ey;
        logic [TEX_W-1:0]  tw;
        logic [TEX_W-1:0]  th;
    } t_geo;

    typedef struct packed {
        logic [COORD_W-1:0] rem;
        logic [DIV_W-1:0]   nq;
    } t_div;

    typedef struct packed {
        t_geo                    geo;
        logic [3:0][DIST_W-1:0]  clip_dist;
        t_div                    div_u;
        t_div                    div_v;
        logic [COORD_W-1:0]      den_u;
        logic [COORD_W-1:0]      den_v;
        logic                    neg_u;
        logic                    neg_v;
        logic                    zero_u;
        logic                    zero_v;
    } t_dstage;

    typedef struct packed {
        t_geo                    geo;
        logic [3:0][DIST_W-1:0]  clip_dist;
        logic [FIX_W-1:0]        step_u;
        logic [FIX_W-1:0]        step_v;
    } t_sstage;

    typedef struct packed {
        t_geo                   geo;
        logic [3:0][PLO_W-1:0]  plo;
        logic [3:0][PLO_W-1:0]  phi;
    } t_m1stage;

    typedef struct packed {
        t_geo                   geo;
        logic [3:0][FIX_W-1:0]  pr;
    } t_m2stage;

    function automatic logic [FIX_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic [FIX_W-1:0] r;
        if (v > $signed(SUM_W'(FIX_MAX))) begin
            r = FIX_MAX;
        end else if (v < -$signed(SUM_W'(FIX_MIN))) begin
            r = FIX_MIN;
        end else begin
            r = v[FIX_W-1:0];
        end
        return r;
    endfunction

endpackage

### hdl/scaled_blit_rect_clip_unit.sv
// Top level: pipelined scaled sprite rectangle clipper with texture step division.
// A request passes through the input, clip, quotient, step, multiply and output registers, in that order.
// Throughput is one request per cycle while the output is not held; the quotient pipeline resolves four bits per stage.
// All stages advance together and hold while the output result waits to be taken.
// Reset is synchronous, active low: it clears all valid bits and loads the default clip box.
module scaled_blit_rect_clip_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // dst_x, dst_y, dst_w, dst_h, tex_width, tex_height, zero pad
    input  logic [sbrc_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // edge_flags, start_x, start_y, start_u, start_v, end_x, end_y, end_u, end_v, zero pad
    output logic [sbrc_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // all_clipped
    output logic                                o_m_tuser,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_idx,
    input  logic [sbrc_pkg::FIX_W-1:0]          i_cfg_data
);

    logic signed [sbrc_pkg::FIX_W-1:0] r_clip_left, r_clip_right, r_clip_top, r_clip_bottom;
    logic [sbrc_pkg::STAGES-1:0]       r_vld;
    logic                              w_en;

    sbrc_pkg::t_astage  r_a, n_a;
    sbrc_pkg::t_dstage  r_d [sbrc_pkg::DIV_STAGES+1];
    sbrc_pkg::t_dstage  n_b;
    sbrc_pkg::t_sstage  r_s, n_s;
    sbrc_pkg::t_m1stage r_m1, n_m1;
    sbrc_pkg::t_m2stage r_m2, n_m2;
    logic [sbrc_pkg::OUT_TDATA_W-1:0] r_tdata, n_tdata;
    logic                             r_tuser, n_tuser;

    function automatic sbrc_pkg::t_div div_step(input sbrc_pkg::t_div d_in,
                                                input logic [sbrc_pkg::COORD_W-1:0] den);
        sbrc_pkg::t_div             r;
        logic [sbrc_pkg::COORD_W:0] t;
        r = d_in;
        for (int i = 0; i < sbrc_pkg::DIV_BITS; i++) begin
            t    = {r.rem, r.nq[sbrc_pkg::DIV_W-1]};
            r.nq = {r.nq[sbrc_pkg::DIV_W-2:0], 1'b0};
            if (t >= {1'b0, den}) begin
                t       = t - {1'b0, den};
                r.nq[0] = 1'b1;
            end
            r.rem = t[sbrc_pkg::COORD_W-1:0];
        end
        return r;
    endfunction

    function automatic sbrc_pkg::t_dstage div_stage(input sbrc_pkg::t_dstage s);
        sbrc_pkg::t_dstage r;
        r       = s;
        r.div_u = div_step(s.div_u, s.den_u);
        r.div_v = div_step(s.div_v, s.den_v);
        return r;
    endfunction

    assign w_en       = !r_vld[sbrc_pkg::STAGES-1] || i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_vld[sbrc_pkg::STAGES-1];
    assign o_m_tdata  = r_tdata;
    assign o_m_tuser  = r_tuser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_left   <= sbrc_pkg::CLIP_LEFT_RST;
            r_clip_right  <= sbrc_pkg::CLIP_RIGHT_RST;
            r_clip_top    <= sbrc_pkg::CLIP_TOP_RST;
            r_clip_bottom <= sbrc_pkg::CLIP_BOTTOM_RST;
        end else if (i_cfg_we) begin
            unique case (sbrc_pkg::t_cfg_idx'(i_cfg_idx))
                sbrc_pkg::CFG_CLIP_LEFT:   r_clip_left   <= i_cfg_data;
                sbrc_pkg::CFG_CLIP_RIGHT:  r_clip_right  <= i_cfg_data;
                sbrc_pkg::CFG_CLIP_TOP:    r_clip_top    <= i_cfg_data;
                sbrc_pkg::CFG_CLIP_BOTTOM: r_clip_bottom <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[sbrc_pkg::STAGES-2:0], i_s_tvalid};
        end
    end

    always_comb begin
        logic [sbrc_pkg::COORD_W-1:0] x, y, w, h;
        x       = i_s_tdata[15:0];
        y       = i_s_tdata[31:16];
        w       = i_s_tdata[47:32];
        h       = i_s_tdata[63:48];
        n_a.x   = x;
        n_a.y   = y;
        n_a.xe  = x + w;
        n_a.ye  = y + h;
        n_a.tw  = i_s_tdata[78:64];
        n_a.th  = i_s_tdata[93:79];
    end

    always_comb begin
        logic signed [sbrc_pkg::FIX_W-1:0]   sx, ex, sy, ey, sxc, syc;
        logic signed [sbrc_pkg::COORD_W:0]   dx, dy, ax, ay;
        logic [3:0]                          fl;
        sx = {r_a.x,  {sbrc_pkg::FRAC_BITS{1'b0}}};
        ex = {r_a.xe, {sbrc_pkg::FRAC_BITS{1'b0}}};
        sy = {r_a.y,  {sbrc_pkg::FRAC_BITS{1'b0}}};
        ey = {r_a.ye, {sbrc_pkg::FRAC_BITS{1'b0}}};
        fl[sbrc_pkg::EDGE_LEFT]   = sx < r_clip_left;
        fl[sbrc_pkg::EDGE_RIGHT]  = ex > r_clip_right;
        fl[sbrc_pkg::EDGE_TOP]    = sy < r_clip_top;
        fl[sbrc_pkg::EDGE_BOTTOM] = ey > r_clip_bottom;
        sxc = fl[sbrc_pkg::EDGE_LEFT] ? r_clip_left : sx;
        syc = fl[sbrc_pkg::EDGE_TOP]  ? r_clip_top  : sy;
        n_b.geo.rej   = (sx >= r_clip_right) || (ex <= r_clip_left) ||
                        (sy >= r_clip_bottom) || (ey <= r_clip_top);
        n_b.geo.flags = fl;
        n_b.geo.sx    = sxc;
        n_b.geo.sy    = syc;
        n_b.geo.ex    = fl[sbrc_pkg::EDGE_RIGHT]  ? r_clip_right  : ex;
        n_b.geo.ey    = fl[sbrc_pkg::EDGE_BOTTOM] ? r_clip_bottom : ey;
        n_b.geo.tw    = r_a.tw;
        n_b.geo.th    = r_a.th;
        n_b.clip_dist[sbrc_pkg::EDGE_LEFT]   =
            sbrc_pkg::DIST_W'(r_clip_left)   - sbrc_pkg::DIST_W'(sx);
        n_b.clip_dist[sbrc_pkg::EDGE_RIGHT]  =
            sbrc_pkg::DIST_W'(r_clip_right)  - sbrc_pkg::DIST_W'(sxc);
        n_b.clip_dist[sbrc_pkg::EDGE_TOP]    =
            sbrc_pkg::DIST_W'(r_clip_top)    - sbrc_pkg::DIST_W'(sy);
        n_b.clip_dist[sbrc_pkg::EDGE_BOTTOM] =
            sbrc_pkg::DIST_W'(r_clip_bottom) - sbrc_pkg::DIST_W'(syc);
        dx = $signed({r_a.xe[sbrc_pkg::COORD_W-1], r_a.xe}) -
             $signed({r_a.x[sbrc_pkg::COORD_W-1], r_a.x});
        dy = $signed({r_a.ye[sbrc_pkg::COORD_W-1], r_a.ye}) -
             $signed({r_a.y[sbrc_pkg::COORD_W-1], r_a.y});
        ax = dx[sbrc_pkg::COORD_W] ? -dx : dx;
        ay = dy[sbrc_pkg::COORD_W] ? -dy : dy;
        n_b.den_u  = ax[sbrc_pkg::COORD_W-1:0];
        n_b.den_v  = ay[sbrc_pkg::COORD_W-1:0];
        n_b.neg_u  = dx[sbrc_pkg::COORD_W];
        n_b.neg_v  = dy[sbrc_pkg::COORD_W];
        n_b.zero_u = (dx == '0);
        n_b.zero_v = (dy == '0);
        n_b.div_u.rem = '0;
        n_b.div_v.rem = '0;
        n_b.div_u.nq  = {1'b0, r_a.tw, {sbrc_pkg::FRAC_BITS{1'b0}}};
        n_b.div_v.nq  = {1'b0, r_a.th, {sbrc_pkg::FRAC_BITS{1'b0}}};
    end

    always_comb begin
        sbrc_pkg::t_dstage d;
        d             = r_d[sbrc_pkg::DIV_STAGES];
        n_s.geo       = d.geo;
        n_s.clip_dist = d.clip_dist;
        n_s.step_u = d.zero_u ? sbrc_pkg::FIX_MAX : (d.neg_u ? -d.div_u.nq : d.div_u.nq);
        n_s.step_v = d.zero_v ? sbrc_pkg::FIX_MAX : (d.neg_v ? -d.div_v.nq : d.div_v.nq);
    end

    always_comb begin
        logic signed [sbrc_pkg::FIX_W-1:0] st;
        logic signed [sbrc_pkg::PLO_W-1:0] lo, hi;
        n_m1.geo = r_s.geo;
        for (int k = 0; k < 4; k++) begin
            st = (k < 2) ? r_s.step_u : r_s.step_v;
            lo = st * $signed({1'b0, r_s.clip_dist[k][sbrc_pkg::FRAC_BITS-1:0]});
            hi = st * $signed(r_s.clip_dist[k][sbrc_pkg::DIST_W-1:sbrc_pkg::FRAC_BITS]);
            n_m1.plo[k] = lo;
            n_m1.phi[k] = hi;
        end
    end

    always_comb begin
        logic signed [sbrc_pkg::SUM_W-1:0] s;
        n_m2.geo = r_m1.geo;
        for (int k = 0; k < 4; k++) begin
            s = $signed(r_m1.phi[k]) + ($signed(r_m1.plo[k]) >>> sbrc_pkg::FRAC_BITS);
            n_m2.pr[k] = sbrc_pkg::sat32(s);
        end
    end

    always_comb begin
        logic signed [sbrc_pkg::FIX_W-1:0] su, sv;
        logic signed [sbrc_pkg::SUM_W-1:0] tu, tv;
        logic [sbrc_pkg::FIX_W-1:0]        eu, ev;
        sbrc_pkg::t_geo                    g;
        g  = r_m2.geo;
        su = g.flags[sbrc_pkg::EDGE_LEFT] ? r_m2.pr[sbrc_pkg::EDGE_LEFT] : '0;
        sv = g.flags[sbrc_pkg::EDGE_TOP]  ? r_m2.pr[sbrc_pkg::EDGE_TOP]  : '0;
        tu = su + $signed(r_m2.pr[sbrc_pkg::EDGE_RIGHT]);
        tv = sv + $signed(r_m2.pr[sbrc_pkg::EDGE_BOTTOM]);
        eu = g.flags[sbrc_pkg::EDGE_RIGHT] ? sbrc_pkg::sat32(tu) :
             {1'b0, g.tw, {sbrc_pkg::FRAC_BITS{1'b0}}};
        ev = g.flags[sbrc_pkg::EDGE_BOTTOM] ? sbrc_pkg::sat32(tv) :
             {1'b0, g.th, {sbrc_pkg::FRAC_BITS{1'b0}}};
        n_tuser = g.rej;
        if (g.rej) begin
            n_tdata = '0;
        end else begin
            n_tdata = {{(sbrc_pkg::OUT_TDATA_W - sbrc_pkg::OUT_FIELDS_W){1'b0}},
                       ev, eu, g.ey, g.ex, sv, su, g.sy, g.sx, g.flags};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a     <= n_a;
            r_d[0]  <= n_b;
            for (int k = 1; k <= sbrc_pkg::DIV_STAGES; k++) begin
                r_d[k] <= div_stage(r_d[k-1]);
            end
            r_s     <= n_s;
            r_m1    <= n_m1;
            r_m2    <= n_m2;
            r_tdata <= n_tdata;
            r_tuser <= n_tuser;
        end
    end

`ifndef SYNTHESIS
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0))
        else $error("rejected result carries nonzero fields");

    a_left_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser && o_m_tdata[0]) |-> ($signed(o_m_tdata[35:4]) == r_clip_left))
        else $error("left clip does not place start_x on the clip edge");

    a_bottom_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser && o_m_tdata[3]) |->
        ($signed(o_m_tdata[195:164]) == r_clip_bottom))
        else $error("bottom clip does not place end_y on the clip edge");
`endif

endmodule
